@@ sv/crc5pf_pkg.sv @@
// Package: shared types and constants of the CRC-5 packet framer.
`default_nettype none
package crc5pf_pkg;

   localparam int OP_W    = 2;
   localparam int VALUE_W = 16;
   localparam int COUNT_W = 16;
   localparam int CRC_W   = 5;
   localparam int BYTE_W  = 8;
   localparam int SLOTS   = 3;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);

   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_BYTE  = 2'd0;
   localparam op_type OP_HALF  = 2'd1;
   localparam op_type OP_CLOSE = 2'd2;

   localparam logic [COUNT_W-1:0] MAX_PAYLOAD_RST = 16'd255;
   localparam logic [CRC_W-1:0]   CRC_INIT        = 5'h1F;
   localparam logic [CRC_W-1:0]   CRC_XOROUT      = 5'h1F;
   localparam logic [CRC_W-1:0]   CRC_POLY_REFL   = 5'h14;
   localparam logic [BYTE_W-1:0]  START_MARK      = 8'h21;
   localparam logic [BYTE_W-1:0]  END_MARK        = 8'h0A;

   // what one output byte slot carries
   typedef logic [1:0] slot_kind_type;
   localparam slot_kind_type SLOT_START = 2'd0;
   localparam slot_kind_type SLOT_DATA  = 2'd1;
   localparam slot_kind_type SLOT_CRC   = 2'd2;
   localparam slot_kind_type SLOT_END   = 2'd3;

   typedef struct packed {
      slot_kind_type     kind;
      logic [BYTE_W-1:0] data;
   } slot_type;

   // one classified transaction: n slots in use, 1..3
   typedef struct packed {
      logic [1:0]           n;
      slot_type [SLOTS-1:0] slot;
   } job_type;

endpackage
`default_nettype wire

@@ sv/crc5pf_if.sv @@
// Interfaces: request and response channels of the CRC-5 packet framer.
`default_nettype none
interface crc5pf_req_if
   import crc5pf_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface crc5pf_rsp_if
   import crc5pf_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

@@ sv/crc5pf_front.sv @@
// Front end: accepts requests, tracks frame/payload state, classifies output bytes.
`default_nettype none
module crc5pf_front
   import crc5pf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   crc5pf_req_if.sink              req,
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data,
   input  wire logic               q_full,
   output logic                    push,
   output job_type                 job
);

   logic [COUNT_W-1:0] max_payload_ff, max_payload_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               open_ff, open_in;
   logic               accept;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      logic [1:0]       k;
      logic             keep_lo;
      logic             keep_hi;
      logic [COUNT_W:0] next_pos;
      k        = 2'd0;
      keep_lo  = count_ff < max_payload_ff;
      next_pos = {1'b0, count_ff} + {{COUNT_W{1'b0}}, 1'b1};
      keep_hi  = keep_lo && (next_pos < {1'b0, max_payload_ff});
      job      = '0;
      count_in = count_ff;
      open_in  = open_ff;
      max_payload_in = csr_wr_en ? csr_wr_data : max_payload_ff;

      if (req.op inside {OP_BYTE, OP_HALF, OP_CLOSE}) begin
         if (!open_ff) begin
            job.slot[k] = '{kind: SLOT_START, data: START_MARK};
            k = k + 2'd1;
         end
         open_in = 1'b1;
      end

      case (req.op)
         OP_BYTE: begin
            if (keep_lo) begin
               job.slot[k] = '{kind: SLOT_DATA, data: req.value[BYTE_W-1:0]};
               k = k + 2'd1;
               count_in = next_pos[COUNT_W-1:0];
            end
         end
         OP_HALF: begin
            if (keep_lo) begin
               job.slot[k] = '{kind: SLOT_DATA, data: req.value[BYTE_W-1:0]};
               k = k + 2'd1;
               count_in = next_pos[COUNT_W-1:0];
            end
            if (keep_hi) begin
               job.slot[k] = '{kind: SLOT_DATA, data: req.value[VALUE_W-1:BYTE_W]};
               k = k + 2'd1;
               count_in = count_ff + 16'd2;
            end
         end
         OP_CLOSE: begin
            job.slot[k] = '{kind: SLOT_CRC, data: '0};
            k = k + 2'd1;
            job.slot[k] = '{kind: SLOT_END, data: END_MARK};
            k = k + 2'd1;
            count_in = '0;
            open_in  = 1'b0;
         end
         default: ;
      endcase

      job.n = k;
      push  = accept && (k != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RST;
         count_ff       <= '0;
         open_ff        <= 1'b0;
      end else begin
         max_payload_ff <= max_payload_in;
         if (accept) begin
            count_ff <= count_in;
            open_ff  <= open_in;
         end
      end
   end

endmodule
`default_nettype wire

@@ sv/crc5pf_queue.sv @@
// Job queue: small FIFO between the front end and the back end.
`default_nettype none
module crc5pf_queue
   import crc5pf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  job_type   push_job,
   input  wire logic pop,
   output logic      full,
   output logic      valid,
   output job_type   head
);

   job_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_pop;

   assign full   = count_ff == (QPTR_W+1)'(QDEPTH);
   assign valid  = count_ff != '0;
   assign head   = mem_ff[rd_ptr_ff];
   assign do_pop = pop && valid;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) count_in = count_ff + 1'b1;
      else if (!push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)   wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/crc5pf_back.sv @@
// Back end: sends queued byte slots, one per ready cycle; runs CRC-5.
`default_nettype none
module crc5pf_back
   import crc5pf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic q_valid,
   input  job_type   head,
   output logic      pop,
   crc5pf_rsp_if.source rsp
);

   function automatic logic [CRC_W-1:0] crc5_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] din);
      logic [BYTE_W-1:0] r;
      r = {3'b000, crc} ^ din;
      for (int i = 0; i < BYTE_W; i++) begin
         if (r[0]) r = (r >> 1) ^ {3'b000, CRC_POLY_REFL};
         else      r = r >> 1;
      end
      return r[CRC_W-1:0];
   endfunction

   logic [1:0]        sel_ff, sel_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;
   logic              load;
   slot_type          cur;

   assign load = q_valid && (!rsp_valid_ff || rsp.ready);
   assign cur  = head.slot[sel_ff];

   always_comb begin
      sel_in       = sel_ff;
      crc_in       = crc_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      pop          = 1'b0;
      if (rsp.ready) rsp_valid_in = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b1;
         last_in      = sel_ff == (head.n - 2'd1);
         case (cur.kind)
            SLOT_START: byte_in = START_MARK;
            SLOT_DATA: begin
               byte_in = cur.data;
               crc_in  = crc5_byte(crc_ff, cur.data);
            end
            SLOT_CRC:   byte_in = {3'b000, crc_ff ^ CRC_XOROUT};
            SLOT_END: begin
               byte_in = END_MARK;
               crc_in  = CRC_INIT;
            end
            default:    byte_in = cur.data;
         endcase
         if (last_in) begin
            pop    = 1'b1;
            sel_in = '0;
         end else begin
            sel_in = sel_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= '0;
         crc_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         sel_ff       <= sel_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = byte_ff;
   assign rsp.last     = last_ff;

endmodule
`default_nettype wire

@@ sv/crc5_packet_framer_unit.sv @@
// Top level: CRC-5 packet framer (front end, job queue, back end).
//
// Usage:
//   req_bus  : valid/ready request channel. op 0 appends the low byte of value,
//              op 1 appends value as low byte then high byte, op 2 closes the
//              frame; op 3 is ignored. A transaction is taken when valid and
//              ready are both high at a rising clock edge.
//   rsp_bus  : valid/ready byte stream of the frame: '!', payload bytes, the
//              reflected CRC-5 (poly 0x05, init and xorout 0x1F), then '\n'.
//              last marks the final byte caused by one request transaction.
//   csr_wr_en/csr_wr_data : writes max_payload (reset 255); write while idle.
//   Payload bytes past max_payload are dropped and stay out of the CRC.
// Each request's bytes pass through the job queue and the output register.
// Throughput: one request per cycle into the job queue (4 deep) while it is not
//   full; one byte per cycle out while rsp_bus is ready; a job holds 1 to 3 bytes.
// Reset (synchronous, active high) empties the queue, closes any open frame
//   and restores max_payload. When the receiver stalls, the output register
//   holds, the queue fills, and req_bus.ready drops once four jobs wait.
`default_nettype none
module crc5_packet_framer_unit
   import crc5pf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   crc5pf_req_if.sink              req_bus,
   crc5pf_rsp_if.source            rsp_bus,
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data
);

   logic    q_full;
   logic    q_valid;
   logic    push;
   logic    pop;
   job_type push_job;
   job_type head;

   // classify each transaction into up to three output slots
   crc5pf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .push        (push),
      .job         (push_job)
   );

   // decouples request acceptance from byte emission
   crc5pf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (q_full),
      .valid    (q_valid),
      .head     (head)
   );

   // one byte per ready cycle; CRC follows emitted payload bytes in order
   crc5pf_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .head    (head),
      .pop     (pop),
      .rsp     (rsp_bus)
   );

   // a pushed job always carries at least one byte slot
   a_job_nonempty: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_job.n != 2'd0))
      else $error("empty job pushed");

   // a close always queues work, so the queue holds a job the next cycle
   a_close_queued: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && (req_bus.op == OP_CLOSE)) |=> q_valid)
      else $error("close transaction produced no queued job");

   // the back end never pops from an empty queue
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("pop with empty queue");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench for the CRC-5 packet framer: queued stimulus, shadow predictor, byte checker.
`timescale 1ns / 100ps
module tb;
   import crc5pf_pkg::*;

   localparam int           CLK_PERIOD     = 10;
   localparam int           RESET_CYCLES   = 11;
   localparam int           DRAIN_CYCLES   = 12;   // queue depth plus pipeline, with margin
   localparam int           STALL_CYCLES   = 300;  // long receiver hold-off
   localparam int           WATCHDOG_LIMIT = 2000; // cycles with no transaction at all
   localparam int           SEGMENTS       = 6;
   localparam int           SEG_ITEMS      = 30;
   localparam op_type       OP_UNUSED      = 2'd3; // no name in the package; block ignores it

   typedef struct packed {
      op_type             op;
      logic [VALUE_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } frame_byte_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;

   crc5pf_req_if req_bus ();
   crc5pf_rsp_if rsp_bus ();

   crc5_packet_framer_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Stimulus queue and the expected output byte stream.
   req_item_type   req_pending_q[$];
   frame_byte_type frame_bytes_q[$];

   // Shadow copy of the framer: register plus frame state.
   logic [COUNT_W-1:0] payload_limit;
   logic [COUNT_W-1:0] kept_count;
   logic [CRC_W-1:0]   crc_acc;
   logic               frame_live;

   // Idle rates in percent, set per phase by the sequencer.
   int src_idle_pct = 28;
   int dst_idle_pct = 72;

   // Bookkeeping.
   int  queued_cnt    = 0;
   int  accepted_cnt  = 0;
   int  bytes_checked = 0;
   int  frames_closed = 0;
   int  bytes_dropped = 0;
   int  fail_count    = 0;
   int  quiet_cycles  = 0;
   bit  req_taken     = 1'b0;

   // Long hold-off requests: sequencer bumps stall_req, the ready process acts on it.
   int  stall_req  = 0;
   int  stall_seen = 0;
   int  hold_left  = 0;

   // One byte through the reflected CRC-5 (USB), LSB first.
   function automatic logic [CRC_W-1:0] crc5_step(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] r;
      r = {3'b000, crc} ^ data;
      for (int i = 0; i < BYTE_W; i++) begin
         if (r[0]) begin
            r = (r >> 1) ^ {3'b000, CRC_POLY_REFL};
         end else begin
            r = r >> 1;
         end
      end
      return r[CRC_W-1:0];
   endfunction

   task automatic emit_expected(input logic [BYTE_W-1:0] data);
      frame_byte_type fb;
      fb.data = data;
      fb.last = 1'b0;
      frame_bytes_q.push_back(fb);
   endtask

   // Payload byte: kept only while below the limit; dropped bytes stay out of the CRC.
   task automatic keep_payload(input logic [BYTE_W-1:0] data);
      if (kept_count < payload_limit) begin
         emit_expected(data);
         crc_acc    = crc5_step(crc_acc, data);
         kept_count = kept_count + 1'b1;
      end else begin
         bytes_dropped++;
      end
   endtask

   // Expected bytes for one accepted request transaction.
   task automatic frame_predict(input op_type op, input logic [VALUE_W-1:0] value);
      int base;
      base = frame_bytes_q.size();
      if (op != OP_UNUSED) begin
         // frame start: any op on a closed frame sends the start marker first
         if (!frame_live) begin
            emit_expected(START_MARK);
            frame_live = 1'b1;
         end
         case (op)
            OP_BYTE: begin
               keep_payload(value[7:0]);
            end
            OP_HALF: begin
               // low byte first; the high byte may fall past the limit alone
               keep_payload(value[7:0]);
               keep_payload(value[15:8]);
            end
            OP_CLOSE: begin
               emit_expected({3'b000, crc_acc ^ CRC_XOROUT});
               emit_expected(END_MARK);
               kept_count = '0;
               crc_acc    = CRC_INIT;
               frame_live = 1'b0;
               frames_closed++;
            end
            default: begin
            end
         endcase
      end
      if (frame_bytes_q.size() > base) begin
         frame_bytes_q[frame_bytes_q.size() - 1].last = 1'b1;
      end
   endtask

   // Predictor and watchdog: sample at the rising edge.
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (reset) begin
         payload_limit = MAX_PAYLOAD_RST;
         kept_count    = '0;
         crc_acc       = CRC_INIT;
         frame_live    = 1'b0;
         quiet_cycles  = 0;
      end else begin
         if (csr_wr_en) begin
            payload_limit = csr_wr_data;
         end
         if (req_bus.valid && req_bus.ready) begin
            req_taken = 1'b1;
            accepted_cnt++;
            frame_predict(req_bus.op, req_bus.value);
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d bytes still expected",
                     quiet_cycles, frame_bytes_q.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Monitor: each output transaction against the oldest expected byte.
   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (frame_bytes_q.size() == 0) begin
            $error("unexpected output transaction: out_byte %h last %b",
                   rsp_bus.out_byte, rsp_bus.last);
            fail_count++;
         end else begin
            want = frame_bytes_q.pop_front();
            bytes_checked++;
            if (rsp_bus.out_byte !== want.data) begin
               $error("out_byte mismatch: expected %h, actual %h", want.data, rsp_bus.out_byte);
               fail_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last mismatch: expected %b, actual %b", want.last, rsp_bus.last);
               fail_count++;
            end
         end
      end
   end

   // Driver: next request presented at the falling edge once the current one is taken.
   always @(negedge clock) begin
      req_item_type nxt;
      if (!reset && (!req_bus.valid || req_taken)) begin
         if (req_pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
            nxt = req_pending_q.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.op    <= nxt.op;
            req_bus.value <= nxt.value;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver: random backpressure, plus an occasional long hold-off counted here.
   always @(negedge clock) begin
      if (stall_req != stall_seen) begin
         stall_seen = stall_req;
         hold_left  = STALL_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= dst_idle_pct);
      end
   end

   task automatic queue_req(input op_type op, input logic [VALUE_W-1:0] value);
      req_item_type it;
      it.op    = op;
      it.value = value;
      req_pending_q.push_back(it);
      queued_cnt++;
   endtask

   // Wait until every request is taken and every byte seen, then wait
   // DRAIN_CYCLES more falling edges before returning.
   task automatic settle_idle();
      while (accepted_cnt != queued_cnt || frame_bytes_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [COUNT_W-1:0] limit);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly well-formed frames with random content; some stray unused ops,
   // empty frames and a few long frames that run past small limits.
   task automatic queue_random_frames(input int n_items);
      int added;
      int len;
      added = 0;
      while (added < n_items) begin
         if ($urandom_range(99) < 8) begin
            queue_req(OP_UNUSED, VALUE_W'($urandom));
         end else begin
            len = ($urandom_range(99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 20);
            for (int i = 0; i < len; i++) begin
               queue_req($urandom_range(1) ? OP_HALF : OP_BYTE, VALUE_W'($urandom));
               added++;
               if ($urandom_range(99) < 5) begin
                  queue_req(OP_UNUSED, VALUE_W'($urandom));
               end
            end
            queue_req(OP_CLOSE, VALUE_W'($urandom));
            added++;
         end
      end
   endtask

   initial begin
      logic [COUNT_W-1:0] seg_limits [SEGMENTS];
      seg_limits[0] = 16'hFFFF;
      seg_limits[1] = 16'd0;
      seg_limits[2] = 16'd1;
      seg_limits[3] = 16'd3;
      seg_limits[4] = 16'd16;
      seg_limits[5] = COUNT_W'($urandom_range(0, 40));

      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_bus.valid = 1'b0;
      req_bus.op    = OP_BYTE;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, reset limit of 255.
      queue_req(OP_CLOSE,  16'h0000);   // empty frame: start, CRC of nothing, end
      queue_req(OP_UNUSED, 16'hFFFF);   // ignored with the frame closed
      queue_req(OP_BYTE,   16'h0000);
      queue_req(OP_BYTE,   16'hABFF);   // upper byte ignored for a single byte
      queue_req(OP_HALF,   16'hFFFF);
      queue_req(OP_HALF,   16'h0000);
      queue_req(OP_UNUSED, 16'h5A5A);   // ignored mid-frame
      queue_req(OP_HALF,   16'h1234);
      queue_req(OP_CLOSE,  16'hFFFF);
      queue_req(OP_HALF,   16'h8001);   // frame opened by a halfword
      queue_req(OP_CLOSE,  16'h0000);
      settle_idle();

      // Halfword split at the bound, then a byte dropped with no output.
      write_limit(16'd2);
      queue_req(OP_BYTE,  16'h0055);
      queue_req(OP_HALF,  16'hA5C3);
      queue_req(OP_BYTE,  16'h0077);
      queue_req(OP_CLOSE, 16'h0000);
      settle_idle();

      // Zero limit: only markers and a zero CRC come out.
      write_limit(16'd0);
      queue_req(OP_BYTE,  16'h0011);
      queue_req(OP_HALF,  16'h2222);
      queue_req(OP_CLOSE, 16'h0000);
      settle_idle();

      // Limit lowered with a frame open: kept bytes stay, later ones drop.
      write_limit(16'd5);
      queue_req(OP_BYTE, 16'h0001);
      queue_req(OP_BYTE, 16'h0002);
      queue_req(OP_BYTE, 16'h0003);
      queue_req(OP_BYTE, 16'h0004);
      settle_idle();
      write_limit(16'd2);
      queue_req(OP_BYTE,  16'h0099);
      queue_req(OP_CLOSE, 16'h0000);
      settle_idle();

      // Random part: receiver-heavy idling, then sender-heavy, then none.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 2) begin
            src_idle_pct = 72;
            dst_idle_pct = 28;
         end
         if (seg == 4) begin
            src_idle_pct = 0;
            dst_idle_pct = 0;
         end
         write_limit(seg_limits[seg]);
         if (seg == 4) begin
            stall_req++;   // fill the job queue while the sender keeps offering
         end
         queue_random_frames(SEG_ITEMS);
         settle_idle();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (frame_bytes_q.size() != 0) begin
         $error("%0d expected output bytes never arrived", frame_bytes_q.size());
         fail_count++;
      end

      $display("Covered %0d request transactions over %0d frames, %0d payload bytes dropped,",
               accepted_cnt, frames_closed, bytes_dropped);
      $display("%0d output bytes checked across limits 255, 2, 0, 5 and six random phases.",
               bytes_checked);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
